// ===== hw/rtl/hfcc_pkg.sv =====
`timescale 1ns / 1ps

package hfcc_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TEMP_CRC = 2'd1;
    localparam logic [1:0] STATUS_HUM_CRC  = 2'd2;

    localparam int TEMP_W = 15;
    localparam int HUM_W  = 14;
    localparam int OUT_TDATA_W = 32;

    // Completed frame, handed from the byte tracker to the scaler
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
    } hfcc_frame_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/hfcc_frame.sv =====
`timescale 1ns / 1ps

module hfcc_frame (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_vld,
    output logic                 byte_rdy,
    input  logic [7:0]           rx_byte,
    input  logic                 frame_start,
    output logic                 frm_vld,
    input  logic                 frm_rdy,
    output hfcc_pkg::hfcc_frame_t frm
);
    import hfcc_pkg::*;

    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] raw_t_reg, raw_t_next;
    logic [15:0] raw_h_reg, raw_h_next;
    logic        tgood_reg, tgood_next;
    logic        frm_vld_reg, frm_vld_next;
    hfcc_frame_t frm_reg, frm_next;

    logic        take;
    logic [2:0]  pos;
    logic [7:0]  crc_fed;

    // A pending frame can hand off in the same cycle a new byte comes in
    assign byte_rdy = !frm_vld_reg || frm_rdy;
    assign take     = byte_vld && byte_rdy;

    always_comb begin
        if (frame_start || pos_reg > POS_H_CRC) begin
            pos = POS_T_MSB;
        end else begin
            pos = pos_reg;
        end
    end

    assign crc_fed = crc8_byte((pos == POS_T_MSB || pos == POS_H_MSB) ? CRC_INIT : crc_reg,
                               rx_byte);

    always_comb begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        raw_t_next   = raw_t_reg;
        raw_h_next   = raw_h_reg;
        tgood_next   = tgood_reg;
        frm_next     = frm_reg;
        frm_vld_next = frm_vld_reg && !frm_rdy;
        if (take) begin
            pos_next = (pos == POS_H_CRC) ? POS_T_MSB : pos + 3'd1;
            unique case (pos)
                POS_T_MSB: begin
                    crc_next   = crc_fed;
                    raw_t_next = {rx_byte, raw_t_reg[7:0]};
                end
                POS_T_LSB: begin
                    crc_next   = crc_fed;
                    raw_t_next = {raw_t_reg[15:8], rx_byte};
                end
                POS_T_CRC: begin
                    tgood_next = (crc_reg == rx_byte);
                    crc_next   = CRC_INIT;
                end
                POS_H_MSB: begin
                    crc_next   = crc_fed;
                    raw_h_next = {rx_byte, raw_h_reg[7:0]};
                end
                POS_H_LSB: begin
                    crc_next   = crc_fed;
                    raw_h_next = {raw_h_reg[15:8], rx_byte};
                end
                default: begin
                    crc_next           = CRC_INIT;
                    frm_vld_next       = 1'b1;
                    frm_next.temp_word = raw_t_reg;
                    frm_next.hum_word  = raw_h_reg;
                    // temperature check wins when both fail
                    if (!tgood_reg) begin
                        frm_next.status = STATUS_TEMP_CRC;
                    end else if (crc_reg != rx_byte) begin
                        frm_next.status = STATUS_HUM_CRC;
                    end else begin
                        frm_next.status = STATUS_OK;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_T_MSB;
            crc_reg     <= CRC_INIT;
            tgood_reg   <= 1'b0;
            frm_vld_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            tgood_reg   <= tgood_next;
            frm_vld_reg <= frm_vld_next;
        end
        raw_t_reg <= raw_t_next;
        raw_h_reg <= raw_h_next;
        frm_reg   <= frm_next;
    end

    assign frm_vld = frm_vld_reg;
    assign frm     = frm_reg;

endmodule

// ===== hw/rtl/hfcc_scale.sv =====
`timescale 1ns / 1ps

module hfcc_scale (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              frm_vld,
    output logic                              frm_rdy,
    input  hfcc_pkg::hfcc_frame_t             frm,
    output logic                              res_vld,
    input  logic                              res_rdy,
    output logic [1:0]                        res_status,
    output logic [hfcc_pkg::OUT_TDATA_W-1:0]  res_data
);
    import hfcc_pkg::*;

    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;

    logic [30:0] t_prod;
    logic [29:0] h_prod;
    logic [31:0] t_sum;
    logic [30:0] h_sum;
    logic [14:0] t_quo;
    logic [13:0] h_quo;
    logic [15:0] t_cent;
    logic        ok;

    logic                   vld_reg, vld_next;
    logic [1:0]             status_reg, status_next;
    logic [OUT_TDATA_W-1:0] data_reg, data_next;

    // x / 65535 = (x + (x >> 16) + 1) >> 16 while the quotient stays below 2^16
    assign t_prod = 31'(frm.temp_word) * 31'(TEMP_SPAN);
    assign h_prod = 30'(frm.hum_word) * 30'(HUM_SPAN);
    assign t_sum  = 32'(t_prod) + 32'(t_prod[30:16]) + 32'd1;
    assign h_sum  = 31'(h_prod) + 31'(h_prod[29:16]) + 31'd1;
    assign t_quo  = t_sum[30:16];
    assign h_quo  = h_sum[29:16];
    assign t_cent = {1'b0, t_quo} - TEMP_OFFSET;
    assign ok     = (frm.status == STATUS_OK);

    assign frm_rdy = !vld_reg || res_rdy;

    always_comb begin
        vld_next    = vld_reg && !res_rdy;
        status_next = status_reg;
        data_next   = data_reg;
        if (frm_vld && frm_rdy) begin
            vld_next    = 1'b1;
            status_next = frm.status;
            data_next   = '0;
            if (ok) begin
                data_next[TEMP_W-1:0]            = t_cent[TEMP_W-1:0];
                data_next[TEMP_W+HUM_W-1:TEMP_W] = h_quo;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        status_reg <= status_next;
        data_reg   <= data_next;
    end

    assign res_vld    = vld_reg;
    assign res_status = status_reg;
    assign res_data   = data_reg;

endmodule

// ===== hw/rtl/humidity_frame_crc_convert.sv =====
`timescale 1ns / 1ps
// Decodes a six-byte temperature/humidity frame with two CRC-8 checks.
// Throughput: one byte per cycle while s_tready is high; frames may follow back to back.
// After the sixth byte is accepted, the frame is registered in the frame stage, then in the output register.
// s_tready falls only while both the frame stage and the output register are full.
// aresetn (synchronous) restarts the byte position and empties both stages.

module humidity_frame_crc_convert (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [7:0] rx_byte
    input  logic                              s_tuser,  // [0] frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [hfcc_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [14:0] temperature_centi,
                                                        // [28:15] humidity_centi
    output logic [1:0]                        m_tuser   // [1:0] status
);
    import hfcc_pkg::*;

    logic        frm_vld;
    logic        frm_rdy;
    hfcc_frame_t frm;

    hfcc_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_vld    (s_tvalid),
        .byte_rdy    (s_tready),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .frm_vld     (frm_vld),
        .frm_rdy     (frm_rdy),
        .frm         (frm)
    );

    hfcc_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .frm_vld    (frm_vld),
        .frm_rdy    (frm_rdy),
        .frm        (frm),
        .res_vld    (m_tvalid),
        .res_rdy    (m_tready),
        .res_status (m_tuser),
        .res_data   (m_tdata)
    );

endmodule

// ===== hw/rtl/hfcc_checker.sv =====
`timescale 1ns / 1ps

module hfcc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [7:0]                        s_tdata,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [hfcc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic [1:0]                        m_tuser
);
    import hfcc_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a fresh result needs a previously accepted request
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a preceding request");

    // CRC failures carry zero readings
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_TEMP_CRC || m_tuser == STATUS_HUM_CRC)
            |-> m_tdata == '0)
        else $error("nonzero readings on CRC error");

    // good frames stay within sensor range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STATUS_TEMP_CRC || m_tuser == STATUS_HUM_CRC
            || (m_tuser == STATUS_OK && m_tdata[TEMP_W+HUM_W-1:TEMP_W] <= 14'd10000
                && $signed(m_tdata[TEMP_W-1:0]) >= -15'sd4500
                && $signed(m_tdata[TEMP_W-1:0]) <= 15'sd13000)))
        else $error("result out of range");

endmodule

bind humidity_frame_crc_convert hfcc_checker u_hfcc_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import hfcc_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 190;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } rx_request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] temp_centi;
        logic [13:0] hum_centi;
    } reading_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'd0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;

    rx_request_t rx_pending[$];
    reading_t    readings_due[$];
    reading_t    reading_want;

    // decoder state as the testbench sees it
    logic [2:0]  frame_pos;
    logic [7:0]  crc_run;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
    logic        temp_crc_ok;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int bytes_accepted = 0;
    int readings_checked = 0;
    int status_seen[3] = '{0, 0, 0};
    int stall_cycles = 0;

    humidity_frame_crc_convert dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc_next(crc_next(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // advance the frame tracker by one accepted byte
    task automatic track_byte(input logic [7:0] b, input logic start);
        logic [2:0] pos;
        reading_t   r;
        int         q;
        int         t;
        pos = start ? 3'd0 : frame_pos;
        if (pos > 3'd5) pos = 3'd0;
        case (pos)
            3'd0: begin
                crc_run = crc_next(CRC_INIT, b);
                temp_raw[15:8] = b;
            end
            3'd1: begin
                crc_run = crc_next(crc_run, b);
                temp_raw[7:0] = b;
            end
            3'd2: begin
                temp_crc_ok = (crc_run == b);
                crc_run = CRC_INIT;
            end
            3'd3: begin
                crc_run = crc_next(CRC_INIT, b);
                hum_raw[15:8] = b;
            end
            3'd4: begin
                crc_run = crc_next(crc_run, b);
                hum_raw[7:0] = b;
            end
            default: begin
                r = '0;
                if (!temp_crc_ok) begin
                    r.status = STATUS_TEMP_CRC;
                end else if (crc_run != b) begin
                    r.status = STATUS_HUM_CRC;
                end else begin
                    r.status = STATUS_OK;
                    q = (17500 * int'(temp_raw)) / 65535;
                    t = q - 4500;
                    r.temp_centi = t[14:0];
                    q = (10000 * int'(hum_raw)) / 65535;
                    r.hum_centi = q[13:0];
                end
                readings_due.push_back(r);
                crc_run = CRC_INIT;
            end
        endcase
        frame_pos = (pos >= 3'd5) ? 3'd0 : pos + 3'd1;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic start);
        rx_request_t req;
        req.rx_byte = b;
        req.frame_start = start;
        rx_pending.push_back(req);
    endtask

    task automatic push_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                              input logic t_bad, input logic h_bad, input logic start);
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = word_crc(t_raw) ^ (t_bad ? 8'($urandom_range(1, 255)) : 8'd0);
        h_crc = word_crc(h_raw) ^ (h_bad ? 8'($urandom_range(1, 255)) : 8'd0);
        push_byte(t_raw[15:8], start);
        push_byte(t_raw[7:0], 1'b0);
        push_byte(t_crc, 1'b0);
        push_byte(h_raw[15:8], 1'b0);
        push_byte(h_raw[7:0], 1'b0);
        push_byte(h_crc, 1'b0);
    endtask

    function automatic logic [15:0] pick_raw();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0) return 16'h0000;
        if (sel == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic queue_random(input int count);
        int sent;
        int n;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 10) begin
                // broken frame: a few loose bytes with random start marks
                n = $urandom_range(1, 5);
                repeat (n) push_byte(8'($urandom), ($urandom_range(99) < 30));
                sent += n;
            end else begin
                push_frame(pick_raw(), pick_raw(), ($urandom_range(99) < 15),
                           ($urandom_range(99) < 15), ($urandom_range(99) < 80));
                sent += 6;
            end
        end
    endtask

    task automatic wait_drained();
        while (rx_pending.size() != 0 || readings_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // input side: take the accepted request, then offer the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            frame_pos = 3'd0;
            crc_run = CRC_INIT;
            temp_raw = '0;
            hum_raw = '0;
            temp_crc_ok = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_byte(s_tdata, s_tuser);
                void'(rx_pending.pop_front());
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= rx_pending[0].rx_byte;
                    s_tuser <= rx_pending[0].frame_start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (readings_due.size() == 0) begin
                    note_mismatch("unexpected result, status", m_tuser, -1);
                end else begin
                    reading_want = readings_due.pop_front();
                    if (m_tuser != reading_want.status)
                        note_mismatch("status", m_tuser, reading_want.status);
                    if (m_tdata[14:0] != reading_want.temp_centi)
                        note_mismatch("temperature_centi", $signed(m_tdata[14:0]),
                                      $signed(reading_want.temp_centi));
                    if (m_tdata[28:15] != reading_want.hum_centi)
                        note_mismatch("humidity_centi", m_tdata[28:15], reading_want.hum_centi);
                    if (reading_want.status <= STATUS_HUM_CRC)
                        status_seen[reading_want.status]++;
                    readings_checked++;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: scale extremes, back-to-back frame without start mark,
        // abandoned partial frame, both CRCs bad, humidity CRC bad
        push_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
        push_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        push_byte(8'hA5, 1'b1);
        push_byte(8'h5A, 1'b0);
        push_frame(16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b1);
        push_frame(16'h1234, 16'hFEDC, 1'b0, 1'b1, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            queue_random(RANDOM_PER_PHASE);
            wait_drained();
        end

        while (readings_due.size() != 0) begin
            reading_want = readings_due.pop_front();
            note_mismatch("missing result, status", -1, reading_want.status);
        end

        $display("%0d bytes sent over four idle/stall phases, %0d readings checked",
                 bytes_accepted, readings_checked);
        $display("status mix: ok %0d, temperature crc %0d, humidity crc %0d",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
